[design/hsfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfc_pkg
// shared constants for the binary16 / binary32 pattern converter
// ----------------------------------------------------------------------------
package hsfc_pkg;

	typedef logic [15:0] half_t;
	typedef logic [31:0] single_t;

	typedef enum logic {
		KIND_S2H = 1'b0,
		KIND_H2S = 1'b1
	} kind_t;

	localparam single_t QNAN_H     = 32'h0000_7e00;
	localparam single_t INF_H      = 32'h0000_7c00;
	localparam single_t MAX_H_AS_S = 32'h477f_e000;
	localparam single_t MIN_NORM_S = 32'h3880_0000;
	localparam single_t MIN_SUB_S  = 32'h3300_0000;
	localparam single_t REBIAS_S   = 32'h3800_0000;
	localparam single_t HALF_ULP   = 32'h0000_1000;
	localparam single_t INF_S      = 32'h7f80_0000;
	localparam logic [7:0] SUB_EXP_BASE = 8'd113;
	localparam logic [7:0] NORM_EXP_ADJ = 8'd112;
	localparam logic [7:0] SUB_SHIFT_BASE = 8'd125;

endpackage
`default_nettype wire

[design/hsfc_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfc channels
// valid/ready channels for request and result words
// ----------------------------------------------------------------------------
interface hsfc_req_if;
	logic                    valid;
	logic                    ready;
	logic                    kind;
	hsfc_pkg::single_t       operand;

	modport source (output valid, output kind, output operand, input ready);
	modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface hsfc_rsp_if;
	logic                    valid;
	logic                    ready;
	hsfc_pkg::single_t       converted;

	modport source (output valid, output converted, input ready);
	modport sink   (input valid, input converted, output ready);
endinterface
`default_nettype wire

[design/hsfc_narrow.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfc_narrow
// binary32 to binary16 pattern narrowing, round half-up on the magnitude
// ----------------------------------------------------------------------------
module hsfc_narrow (
	input  wire hsfc_pkg::single_t operand,
	output hsfc_pkg::half_t        half
);

	logic              sign;
	hsfc_pkg::single_t mag;
	logic [7:0]        exp8;
	logic [23:0]       sig;
	logic [7:0]        shift_full;
	logic [4:0]        shift_m1;
	logic [23:0]       shifted;
	logic [11:0]       rounded;
	hsfc_pkg::single_t norm_sum;

	assign sign       = operand[31];
	assign mag        = {1'b0, operand[30:0]};
	assign exp8       = mag[30:23];
	assign sig        = {1'b1, mag[22:0]};
	assign shift_full = 8'(hsfc_pkg::SUB_SHIFT_BASE - exp8);
	assign shift_m1   = shift_full[4:0];
	assign shifted    = sig >> shift_m1;
	assign rounded    = 12'({1'b0, shifted[10:0]} + 12'd1) >> 1;
	assign norm_sum   = 32'(mag - hsfc_pkg::REBIAS_S + hsfc_pkg::HALF_ULP);

	always_comb begin
		if (mag > hsfc_pkg::INF_S) begin
			half = {sign, hsfc_pkg::QNAN_H[14:0]};
		end else if (mag > hsfc_pkg::MAX_H_AS_S) begin
			half = {sign, hsfc_pkg::INF_H[14:0]};
		end else if (mag < hsfc_pkg::MIN_SUB_S) begin
			half = {sign, 15'd0};
		end else if (mag < hsfc_pkg::MIN_NORM_S) begin
			half = {sign, 4'd0, rounded[10:0]};
		end else begin
			half = {sign, norm_sum[27:13]};
		end
	end

endmodule
`default_nettype wire

[design/hsfc_widen.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfc_widen
// exact binary16 to binary32 pattern widening with subnormal normalization
// ----------------------------------------------------------------------------
module hsfc_widen (
	input  wire hsfc_pkg::half_t   half,
	output hsfc_pkg::single_t      single
);

	logic       sign;
	logic [4:0] ex;
	logic [9:0] man;
	logic [3:0] msb_pos;
	logic [3:0] norm_shift;
	logic [9:0] man_norm;
	logic [7:0] exp_sub;
	logic [7:0] exp_norm;

	assign sign = half[15];
	assign ex   = half[14:10];
	assign man  = half[9:0];

	// leading one of the subnormal mantissa
	always_comb begin
		msb_pos = '0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				msb_pos = 4'(i);
			end
		end
	end

	assign norm_shift = 4'(4'd10 - msb_pos);
	assign man_norm   = 10'(man << norm_shift);
	assign exp_sub    = 8'(hsfc_pkg::SUB_EXP_BASE - {4'd0, norm_shift});
	assign exp_norm   = 8'({3'd0, ex} + hsfc_pkg::NORM_EXP_ADJ);

	always_comb begin
		if (ex == 5'd0) begin
			if (man == 10'd0) begin
				single = {sign, 31'd0};
			end else begin
				single = {sign, exp_sub, man_norm, 13'd0};
			end
		end else if (ex == 5'h1f) begin
			single = {sign, hsfc_pkg::INF_S[30:23], man, 13'd0};
		end else begin
			single = {sign, exp_norm, man, 13'd0};
		end
	end

endmodule
`default_nettype wire

[design/half_single_float_convert_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// half_single_float_convert_core
// binary16 <-> binary32 pattern converter, while result is ready one word per cycle
// ----------------------------------------------------------------------------
// path: an accepted word goes into the input register, then into the result register that drives result
// throughput: one word per cycle while result is ready, input register feeds the result register
// a stalled result holds while the input register still takes one more word
// reset: arst_n clears both stage valid flags, payload registers are not reset
// ----------------------------------------------------------------------------
module half_single_float_convert_core (
	input  wire            clk,
	input  wire            arst_n,
	hsfc_req_if.sink       request,
	hsfc_rsp_if.source     result
);

	logic              valid_s1;
	logic              kind_s1;
	hsfc_pkg::single_t operand_s1;
	logic              valid_s2;
	logic              kind_s2;
	hsfc_pkg::single_t converted_s2;
	logic              load_s2;
	hsfc_pkg::half_t   narrowed;
	hsfc_pkg::single_t widened;
	hsfc_pkg::single_t converted_next;

	assign load_s2       = valid_s1 && (!valid_s2 || result.ready);
	assign request.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			kind_s1    <= request.kind;
			operand_s1 <= request.operand;
		end
	end

	hsfc_narrow u_narrow (
		.operand (operand_s1),
		.half    (narrowed)
	);

	hsfc_widen u_widen (
		.half   (operand_s1[15:0]),
		.single (widened)
	);

	always_comb begin
		case (hsfc_pkg::kind_t'(kind_s1))
			hsfc_pkg::KIND_S2H: converted_next = {16'd0, narrowed};
			hsfc_pkg::KIND_H2S: converted_next = widened;
			default:            converted_next = {16'd0, narrowed};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			kind_s2      <= kind_s1;
			converted_s2 <= converted_next;
		end
	end

	assign result.valid     = valid_s2;
	assign result.converted = converted_s2;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!request.ready |-> valid_s1 && valid_s2)
		else $error("request stalled with a free stage");

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> result.valid)
		else $error("stage advance lost the result word");

	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (kind_s2 == hsfc_pkg::KIND_S2H) |->
		result.converted[31:16] == 16'd0)
		else $error("narrowed result has upper bits set");
`endif

endmodule
`default_nettype wire

[verif/tb_half_single_float_convert_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_half_single_float_convert_core
// drives binary32 and binary16 patterns into the converter and checks each
// result word against a bit-exact model of the narrowing and widening rules,
// with random gaps on both channels and a long result stall
// ----------------------------------------------------------------------------
module tb_half_single_float_convert_core;
	import hsfc_pkg::*;

	localparam single_t SGL_INF          = 32'h7f80_0000;
	localparam single_t SGL_HALF_MAX     = 32'h477f_e000;
	localparam single_t SGL_HALF_MIN_NRM = 32'h3880_0000;
	localparam single_t SGL_HALF_MIN_SUB = 32'h3300_0000;
	localparam single_t SGL_REBIAS       = 32'h3800_0000;
	localparam single_t SGL_ROUND_BIT    = 32'h0000_1000;
	localparam half_t   HLF_QNAN         = 16'h7e00;
	localparam half_t   HLF_INF          = 16'h7c00;

	localparam int N_NARROW = 16;
	localparam int N_WIDEN  = 10;

	localparam single_t NARROW_CASES [N_NARROW] = '{
		32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
		32'h7fc0_0001, 32'hff80_0001, 32'h477f_e000, 32'h477f_e001,
		32'hc77f_f000, 32'h3300_0000, 32'h32ff_ffff, 32'h387f_ffff,
		32'h3880_0000, 32'h3f80_1000, 32'hbf80_0fff, 32'hb350_0000
	};

	localparam single_t WIDEN_CASES [N_WIDEN] = '{
		32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_83ff,
		32'h0000_0400, 32'h0000_7bff, 32'h0000_fc00, 32'h0000_7e00,
		32'h0000_7c01, 32'hdead_ffff
	};

	logic clk = 1'b0;
	logic arst_n;

	hsfc_req_if request_ch ();
	hsfc_rsp_if result_ch ();

	half_single_float_convert_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch)
	);

	single_t converted_q [$];
	single_t want_word;
	int      err_count = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      holdoff_cycles = 0;

	always #2 clk = ~clk;

	function automatic half_t narrow_to_half(single_t x);
		single_t mag;
		single_t sig;
		single_t rnd;
		half_t   sgn;
		int unsigned sh;
		sgn = {x[31], 15'b0};
		mag = {1'b0, x[30:0]};
		if (mag > SGL_INF)
			return sgn | HLF_QNAN;
		if (mag > SGL_HALF_MAX)
			return sgn | HLF_INF;
		if (mag < SGL_HALF_MIN_SUB)
			return sgn;
		if (mag < SGL_HALF_MIN_NRM) begin
			sig = {8'b0, 1'b1, mag[22:0]};
			sh = 126 - mag[30:23];
			rnd = (sig + (32'd1 << (sh - 1))) >> sh;
			return sgn | rnd[15:0];
		end
		rnd = (mag - SGL_REBIAS + SGL_ROUND_BIT) >> 13;
		return sgn | rnd[15:0];
	endfunction

	function automatic single_t widen_to_single(half_t h);
		single_t sgn;
		single_t man;
		int unsigned ex;
		int unsigned k;
		sgn = {h[15], 31'b0};
		ex = h[14:10];
		man = {22'b0, h[9:0]};
		k = 0;
		if (ex == 0) begin
			if (man == 0)
				return sgn;
			while (!man[10] && k < 11) begin
				man = man << 1;
				k++;
			end
			man &= 32'h0000_03ff;
			return sgn | single_t'((113 - k) << 23) | (man << 13);
		end
		if (ex == 31)
			return sgn | SGL_INF | (man << 13);
		return sgn | single_t'((ex + 112) << 23) | (man << 13);
	endfunction

	function automatic single_t predict_converted(kind_t k, single_t op);
		if (k == KIND_S2H)
			return {16'b0, narrow_to_half(op)};
		return widen_to_single(op[15:0]);
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input kind_t k, input single_t op);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request_ch.valid   <= 1'b1;
		request_ch.kind    <= k;
		request_ch.operand <= op;
		do
			@(posedge clk);
		while (!(request_ch.valid && request_ch.ready));
		@(negedge clk);
		converted_q.push_back(predict_converted(k, op));
	endtask

	task automatic wait_drained();
		request_ch.valid <= 1'b0;
		while (converted_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_narrow_directed();
		for (int i = 0; i < N_NARROW; i++)
			send_word(KIND_S2H, NARROW_CASES[i]);
	endtask

	task automatic test_widen_directed();
		for (int i = 0; i < N_WIDEN; i++)
			send_word(KIND_H2S, WIDEN_CASES[i]);
	endtask

	task automatic test_random_words(input int count);
		kind_t   k;
		single_t op;
		single_t base;
		half_t   h;
		int      sel;
		for (int i = 0; i < count; i++) begin
			k = kind_t'($urandom_range(1));
			sel = $urandom_range(11);
			if (k == KIND_S2H) begin
				case (sel)
					0, 1, 2: begin
						op = $urandom;
					end
					3, 4, 5, 6, 7: begin
						op = {1'($urandom), 8'($urandom_range(100, 145)), 23'($urandom)};
					end
					8: begin
						op = {1'($urandom), 8'($urandom_range(103, 142)), 10'($urandom),
							13'h1000};
					end
					9, 10: begin
						case ($urandom_range(3))
							0: base = SGL_HALF_MAX;
							1: base = SGL_HALF_MIN_NRM;
							2: base = SGL_HALF_MIN_SUB;
							default: base = SGL_INF;
						endcase
						op = base + $urandom_range(8) - 4;
						op[31] = 1'($urandom);
					end
					default: begin
						op = {1'($urandom), 8'hff, $urandom_range(1) ? 23'($urandom) : 23'h0};
					end
				endcase
			end else begin
				case (sel)
					0, 1, 2, 3, 4, 5: h = 16'($urandom);
					6, 7, 8: h = {1'($urandom), 5'h00, 10'($urandom)};
					default: h = {1'($urandom), 5'h1f,
						$urandom_range(1) ? 10'($urandom) : 10'h0};
				endcase
				op = {16'($urandom), h};
			end
			send_word(k, op);
		end
	endtask

	task automatic test_result_stall();
		@(posedge clk);
		holdoff_cycles = 60;
		@(negedge clk);
		for (int i = 0; i < 24; i++)
			send_word(kind_t'($urandom_range(1)), $urandom);
		wait_drained();
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				result_ch.ready <= 1'b0;
				holdoff_cycles--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (converted_q.size() == 0) begin
				$error("converted: unexpected word %h", result_ch.converted);
				err_count++;
			end else begin
				want_word = converted_q.pop_front();
				if (result_ch.converted !== want_word) begin
					$error("converted: expected %h, actual %h", want_word,
						result_ch.converted);
					err_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.kind = KIND_S2H;
		request_ch.operand = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 61;
		test_narrow_directed();
		test_widen_directed();
		test_random_words(470);
		wait_drained();

		send_idle_pct = 61;
		recv_idle_pct = 18;
		test_random_words(470);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_words(470);
		wait_drained();
		test_result_stall();

		repeat (8) @(posedge clk);
		if (converted_q.size() != 0) begin
			$error("converted: %0d words never arrived", converted_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
